// ===== src/glyph_pixel_rasterizer_macros.svh =====
// Assertion helpers shared by the rasteriser sources.
// Every check is sampled on clk_i and held off while rst_ni is low.
`ifndef GLYPH_PIXEL_RASTERIZER_MACROS_SVH
`define GLYPH_PIXEL_RASTERIZER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds.
`define GPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds.
`define GPR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define GPR_ASSERT(lbl, prop)
`define GPR_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== src/gpr_pkg.sv =====
`default_nettype none

package gpr_pkg;

  // Character range held in the font ROM
  localparam int unsigned GLYPH_COUNT = 95;
  localparam logic [7:0]  FIRST_CODE  = 8'd32;
  localparam logic [7:0]  FINAL_CODE  = 8'd126;

  // Cell geometry: five glyph columns and one spacing column of seven rows
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam logic [2:0]  LAST_COL    = 3'd5;
  localparam logic [2:0]  LAST_ROW    = 3'd6;
  localparam int unsigned GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [8:0] WIDTH_RESET  = 9'd128;
  localparam logic [8:0] HEIGHT_RESET = 9'd160;

  // Visible screen size
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
  } screen_t;

  // One classified draw job; glyph column c sits in bits [c*7 +: 7]
  typedef struct packed {
    logic [7:0]            anchor_x;
    logic [7:0]            anchor_y;
    logic [GLYPH_BITS-1:0] glyph;
    logic [15:0]           fore_colour;
    logic [15:0]           back_colour;
    logic                  paint_back;
  } job_t;

  // Font ROM: five column bytes, column 0 in the top byte, bit 0 is the top row
  function automatic logic [39:0] glyph_rom(logic [6:0] idx);
    logic [39:0] r;
    case (idx)
      7'd0:  r = 40'h0000000000;
      7'd1:  r = 40'h00005F0000;
      7'd2:  r = 40'h0007000700;
      7'd3:  r = 40'h147F147F14;
      7'd4:  r = 40'h242A7F2A12;
      7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649552250;
      7'd7:  r = 40'h0005030000;
      7'd8:  r = 40'h001C224100;
      7'd9:  r = 40'h0041221C00;
      7'd10: r = 40'h082A1C2A08;
      7'd11: r = 40'h08083E0808;
      7'd12: r = 40'h0050300000;
      7'd13: r = 40'h0808080808;
      7'd14: r = 40'h0060600000;
      7'd15: r = 40'h2010080402;
      7'd16: r = 40'h3E5149453E;
      7'd17: r = 40'h00427F4000;
      7'd18: r = 40'h4261514946;
      7'd19: r = 40'h2141454B31;
      7'd20: r = 40'h1814127F10;
      7'd21: r = 40'h2745454539;
      7'd22: r = 40'h3C4A494930;
      7'd23: r = 40'h0171090503;
      7'd24: r = 40'h3649494936;
      7'd25: r = 40'h064949291E;
      7'd26: r = 40'h0036360000;
      7'd27: r = 40'h0056360000;
      7'd28: r = 40'h0008142241;
      7'd29: r = 40'h1414141414;
      7'd30: r = 40'h4122140800;
      7'd31: r = 40'h0201510906;
      7'd32: r = 40'h324979413E;
      7'd33: r = 40'h7E1111117E;
      7'd34: r = 40'h7F49494936;
      7'd35: r = 40'h3E41414122;
      7'd36: r = 40'h7F4141221C;
      7'd37: r = 40'h7F49494941;
      7'd38: r = 40'h7F09090101;
      7'd39: r = 40'h3E41415132;
      7'd40: r = 40'h7F0808087F;
      7'd41: r = 40'h00417F4100;
      7'd42: r = 40'h2040413F01;
      7'd43: r = 40'h7F08142241;
      7'd44: r = 40'h7F40404040;
      7'd45: r = 40'h7F0204027F;
      7'd46: r = 40'h7F0408107F;
      7'd47: r = 40'h3E4141413E;
      7'd48: r = 40'h7F09090906;
      7'd49: r = 40'h3E4151215E;
      7'd50: r = 40'h7F09192946;
      7'd51: r = 40'h4649494931;
      7'd52: r = 40'h01017F0101;
      7'd53: r = 40'h3F4040403F;
      7'd54: r = 40'h1F2040201F;
      7'd55: r = 40'h7F2018207F;
      7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0304780403;
      7'd58: r = 40'h6151494543;
      7'd59: r = 40'h00007F4141;
      7'd60: r = 40'h0204081020;
      7'd61: r = 40'h41417F0000;
      7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040;
      7'd64: r = 40'h0001020400;
      7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7F48444438;
      7'd67: r = 40'h3844444420;
      7'd68: r = 40'h384444487F;
      7'd69: r = 40'h3854545418;
      7'd70: r = 40'h087E090102;
      7'd71: r = 40'h081454543C;
      7'd72: r = 40'h7F08040478;
      7'd73: r = 40'h00447D4000;
      7'd74: r = 40'h2040443D00;
      7'd75: r = 40'h7F10284400;
      7'd76: r = 40'h00417F4000;
      7'd77: r = 40'h7C04180478;
      7'd78: r = 40'h7C08040478;
      7'd79: r = 40'h3844444438;
      7'd80: r = 40'h7C14141408;
      7'd81: r = 40'h081414187C;
      7'd82: r = 40'h7C08040408;
      7'd83: r = 40'h4854545420;
      7'd84: r = 40'h043F444020;
      7'd85: r = 40'h3C4040207C;
      7'd86: r = 40'h1C2040201C;
      7'd87: r = 40'h3C4030403C;
      7'd88: r = 40'h4428102844;
      7'd89: r = 40'h0C5050503C;
      7'd90: r = 40'h4464544C44;
      7'd91: r = 40'h0008364100;
      7'd92: r = 40'h00007F0000;
      7'd93: r = 40'h0041360800;
      7'd94: r = 40'h0804081008;
      default: r = 40'h0000000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/gpr_front.sv =====
`default_nettype none

module gpr_front (
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire logic [7:0]   anchor_x_i,
  input  wire logic [7:0]   anchor_y_i,
  input  wire logic [7:0]   char_code_i,
  input  wire logic [15:0]  fore_colour_i,
  input  wire logic [15:0]  back_colour_i,
  output logic              push_o,
  output gpr_pkg::job_t     job_o
);

  logic [7:0]  glyph_idx;
  logic        drawable;
  logic [39:0] rom_word;

  // Classify the code: printable and held in the ROM
  assign glyph_idx = char_code_i - gpr_pkg::FIRST_CODE;
  assign drawable  = (char_code_i >= gpr_pkg::FIRST_CODE) &&
                     (char_code_i <= gpr_pkg::FINAL_CODE) &&
                     ({24'd0, glyph_idx} < 32'(gpr_pkg::GLYPH_COUNT));
  assign rom_word  = gpr_pkg::glyph_rom(glyph_idx[6:0]);

  // Drop undrawable beats here; queue the rest
  assign push_o = in_valid_i && in_ready_i && drawable;

  // Repack the ROM columns, column 0 in the low bits
  always_comb begin
    job_o.anchor_x    = anchor_x_i;
    job_o.anchor_y    = anchor_y_i;
    job_o.fore_colour = fore_colour_i;
    job_o.back_colour = back_colour_i;
    job_o.paint_back  = (fore_colour_i != back_colour_i);
    for (int c = 0; c < gpr_pkg::GLYPH_COLS; c++) begin
      job_o.glyph[c*gpr_pkg::GLYPH_ROWS +: gpr_pkg::GLYPH_ROWS] =
        rom_word[(gpr_pkg::GLYPH_COLS-1-c)*8 +: gpr_pkg::GLYPH_ROWS];
    end
  end

endmodule

`default_nettype wire

// ===== src/gpr_queue.sv =====
`default_nettype none

module gpr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire gpr_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output gpr_pkg::job_t      job_o
);

  gpr_pkg::job_t                 store_q [gpr_pkg::QUEUE_DEPTH];
  logic [gpr_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gpr_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gpr_pkg::QCNT_W-1:0]    count_q, count_d;

  assign full_o  = (count_q == gpr_pkg::QCNT_W'(gpr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = store_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == gpr_pkg::QPTR_W'(gpr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == gpr_pkg::QPTR_W'(gpr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/gpr_back.sv =====
`default_nettype none

`include "glyph_pixel_rasterizer_macros.svh"

module gpr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire gpr_pkg::screen_t screen_i,
  input  wire logic             job_valid_i,
  input  wire gpr_pkg::job_t    job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            pixel_x_o,
  output logic [7:0]            pixel_y_o,
  output logic [15:0]           pixel_colour_o,
  output logic                  last_pixel_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] colour;
  } pixel_t;

  back_state_e                    state_q, state_d;
  gpr_pkg::job_t                  job_q, job_d;
  logic [gpr_pkg::GLYPH_BITS-1:0] glyph_q, glyph_d;
  logic [2:0]                     col_q, col_d;
  logic [2:0]                     row_q, row_d;
  logic                           pend_valid_q, pend_valid_d;
  pixel_t                         pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;
  pixel_t                         out_q, out_d;
  logic                           out_last_q, out_last_d;

  logic   cur_bit;
  logic   on_screen;
  logic   emit;
  logic   out_free;
  logic   advance;
  pixel_t cand;

  // Examine the current cell
  assign cur_bit     = glyph_q[row_q];
  assign cand.x      = job_q.anchor_x + {5'd0, col_q};
  assign cand.y      = job_q.anchor_y + {5'd0, row_q};
  assign cand.colour = cur_bit ? job_q.fore_colour : job_q.back_colour;
  assign on_screen   = ({1'b0, cand.x} < screen_i.width) &&
                       ({1'b0, cand.y} < screen_i.height);
  assign emit        = on_screen && (cur_bit || job_q.paint_back);
  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = !(emit && pend_valid_q && !out_free);

  // Walk the cell; one pixel is held back so the final one can be flagged
  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    glyph_d      = glyph_q;
    col_d        = col_q;
    row_d        = row_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          glyph_d = job_i.glyph;
          col_d   = '0;
          row_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (emit) begin
            pend_valid_d = 1'b1;
            pend_d       = cand;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              out_last_d  = 1'b0;
            end
          end
          if (row_q == gpr_pkg::LAST_ROW) begin
            row_d   = '0;
            col_d   = col_q + 1'b1;
            glyph_d = glyph_q >> gpr_pkg::GLYPH_ROWS;
            if (col_q == gpr_pkg::LAST_COL) begin
              state_d = ST_FLUSH;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    glyph_q    <= glyph_d;
    col_q      <= col_d;
    row_q      <= row_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = out_q.x;
  assign pixel_y_o      = out_q.y;
  assign pixel_colour_o = out_q.colour;
  assign last_pixel_o   = out_last_q;

  `GPR_ASSERT(pend_only_busy, pend_valid_q |-> (state_q != ST_IDLE))
  `GPR_ASSERT_NEVER(row_in_range, (state_q == ST_SCAN) && (row_q > gpr_pkg::LAST_ROW))
  `GPR_ASSERT(scan_ends_in_flush,
    ((state_q == ST_SCAN) && advance && (col_q == gpr_pkg::LAST_COL) &&
     (row_q == gpr_pkg::LAST_ROW)) |=> (state_q == ST_FLUSH))
  `GPR_ASSERT(out_on_screen,
    out_valid_q |-> (({1'b0, out_q.x} < screen_i.width) &&
                     ({1'b0, out_q.y} < screen_i.height)))

endmodule

`default_nettype wire

// ===== src/glyph_pixel_rasterizer.sv =====
// Per drawable character the back end loads the job, walks 42 cell steps and flushes.
// Undrawable codes are dropped in the front end in the cycle they are accepted.
// First pixel passes the queue, job and pending registers; each pixel waits for the next.
// Output stalls hold the cell walk only when a pixel must move to the output register.
// rst_ni clears the queue and control state asynchronously; size resets to 128 x 160.
`default_nettype none

module glyph_pixel_rasterizer (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // anchor_x [7:0], anchor_y [15:8], char_code [23:16],
  // fore_colour [39:24], back_colour [55:40]
  input  wire logic [55:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pixel_x [7:0], pixel_y [15:8], pixel_colour [31:16]
  output logic [31:0]       m_tdata,
  output logic              m_tlast,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_idx_i,
  input  wire logic [8:0]   cfg_data_i
);

  gpr_pkg::screen_t screen_q, screen_d;
  gpr_pkg::job_t    front_job;
  gpr_pkg::job_t    queue_job;
  logic             push;
  logic             pop;
  logic             full;
  logic             queue_valid;
  logic [7:0]       pixel_x;
  logic [7:0]       pixel_y;
  logic [15:0]      pixel_colour;

  // Register writes
  always_comb begin
    screen_d = screen_q;
    if (cfg_we_i) begin
      unique case (gpr_pkg::cfg_reg_e'(cfg_idx_i))
        gpr_pkg::REG_SCREEN_WIDTH:  screen_d.width  = cfg_data_i;
        gpr_pkg::REG_SCREEN_HEIGHT: screen_d.height = cfg_data_i;
        default: screen_d = screen_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q.width  <= gpr_pkg::WIDTH_RESET;
      screen_q.height <= gpr_pkg::HEIGHT_RESET;
    end else begin
      screen_q <= screen_d;
    end
  end

  assign s_tready = !full;

  gpr_front u_front (
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .anchor_x_i    (s_tdata[7:0]),
    .anchor_y_i    (s_tdata[15:8]),
    .char_code_i   (s_tdata[23:16]),
    .fore_colour_i (s_tdata[39:24]),
    .back_colour_i (s_tdata[55:40]),
    .push_o        (push),
    .job_o         (front_job)
  );

  gpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .job_o   (queue_job)
  );

  gpr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .screen_i       (screen_q),
    .job_valid_i    (queue_valid),
    .job_i          (queue_job),
    .pop_o          (pop),
    .out_valid_o    (m_tvalid),
    .out_ready_i    (m_tready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_colour_o (pixel_colour),
    .last_pixel_o   (m_tlast)
  );

  assign m_tdata = {pixel_colour, pixel_y, pixel_x};

endmodule

`default_nettype wire
